[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

[hw/rtl/rrpas_pkg.sv]
`default_nettype none
package rrpas_pkg;

	localparam int MAX_PROCS     = 8;
	localparam int SLOT_W        = $clog2(MAX_PROCS);
	localparam int CNT_W         = $clog2(MAX_PROCS + 1);
	localparam int ID_W          = 16;
	localparam int BURST_W       = 16;
	localparam int PRIO_W        = 7;
	localparam int TICK_W        = 9;
	localparam int TICKS_MAX     = (1 << TICK_W) - 1;
	localparam int PCNT_W        = 4;
	localparam int QUANT_W       = 8;
	localparam int QUANTUM_RESET = 30;
	localparam int AGING_STRIDE  = 2;
	localparam int IN_TDATA_W    = 48;
	localparam int OUT_TDATA_W   = 40;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_TICK = 1'b1
	} action_t;

	typedef enum logic {
		REG_PROCESS_COUNT = 1'b0,
		REG_QUANTUM_TICKS = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FIND,
		ST_EVAL,
		ST_RUN,
		ST_SORT,
		ST_COMMIT,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		TRY_SWEEP,
		TRY_RESTART,
		TRY_SWITCHED
	} attempt_t;

	typedef struct packed {
		logic              load;
		logic              clear_res;
		logic              find;
		logic              from_zero;
		logic              do_switch;
		logic              reset_sp;
		logic              run;
		logic              sort_step;
		logic [SLOT_W-1:0] sort_idx;
		logic              sort_commit;
		logic              emit;
	} dp_cmd_t;

	typedef struct packed {
		logic none_left;
		logic found;
		logic quantum_hit;
		logic phase;
		logic age_due;
		logic out_free;
	} dp_status_t;

endpackage
`default_nettype wire

[hw/rtl/round_robin_priority_aging_scheduler_unit.sv]
`default_nettype none
// Process scheduler that alternates a round robin phase and an aging priority phase.
// The slave stream carries requests: tuser 0 loads a table slot from tdata, tuser 1
// asks for one scheduling tick. A load writes the table slot as it is accepted and gives no result.
// A tick gives exactly one result on the master stream: tuser says whether a
// process ran, tdata holds its slot, identifier, remaining burst, the phase and
// the all-done flag.
// A plain tick passes CHECK, FIND, EVAL, RUN and FINISH before a valid result. The priority
// order is rebuilt by a sort unit that ranks one slot per cycle, so each re-sort
// (after aging, or on entry to the priority phase) adds the SORT and COMMIT states; the worst tick,
// which enters the priority phase at a sweep end and then ages, re-sorts twice.
// One tick is in work at a time: a new tick is taken only once the last one is emitted. The next
// request is taken once the result sits in the output register, so a stalled
// receiver lets one more tick be taken, which then waits for the output register.
// Reset empties the output register, selects the round robin phase with identity
// order, clears the sweep and tick counters, and sets process_count to 0 and
// quantum_ticks to 30. Table contents are undefined until loaded.
// Registers on the APB port: process_count at 0x0, quantum_ticks at 0x4.
module round_robin_priority_aging_scheduler_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire [rrpas_pkg::APB_ADDR_W-1:0]      paddr,
	input  wire [rrpas_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [rrpas_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                 pready,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	input  wire [rrpas_pkg::IN_TDATA_W-1:0]      s_tdata,  // slot, proc_id, burst, priority_req
	input  wire                                  s_tuser,  // action
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [rrpas_pkg::OUT_TDATA_W-1:0]    m_tdata,  // ran_slot, ran_id, burst_left,
	                                                       // priority_mode, all_done
	output logic                                 m_tuser   // ran
);
	import rrpas_pkg::*;

	logic [PCNT_W-1:0]  pcount_q;
	logic [QUANT_W-1:0] quantum_q;
	logic               cfg_write;
	dp_cmd_t            cmd;
	dp_status_t         status;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q  <= '0;
			quantum_q <= QUANT_W'(QUANTUM_RESET);
		end else if (cfg_write) begin
			unique case (reg_index_t'(paddr[2]))
				REG_PROCESS_COUNT: pcount_q  <= pwdata[PCNT_W-1:0];
				REG_QUANTUM_TICKS: quantum_q <= pwdata[QUANT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index_t'(paddr[2]))
			REG_PROCESS_COUNT: prdata = APB_DATA_W'(pcount_q);
			REG_QUANTUM_TICKS: prdata = APB_DATA_W'(quantum_q);
			default:           prdata = '0;
		endcase
	end

	rrpas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rrpas_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.process_count (pcount_q),
		.quantum_ticks (quantum_q),
		.s_tdata       (s_tdata),
		.m_tready      (m_tready),
		.cmd           (cmd),
		.status        (status),
		.m_tvalid      (m_tvalid),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser)
	);

endmodule
`default_nettype wire

[hw/rtl/rrpas_ctrl.sv]
`default_nettype none
module rrpas_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_tvalid,
	input  wire                     s_tuser,
	output logic                    s_tready,
	input  wire rrpas_pkg::dp_status_t status,
	output rrpas_pkg::dp_cmd_t      cmd
);
	import rrpas_pkg::*;

	state_t            state_q, state_n;
	attempt_t          attempt_q, attempt_n;
	logic [SLOT_W-1:0] sort_idx_q, sort_idx_n;
	logic              to_finish_q, to_finish_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			attempt_q   <= TRY_SWEEP;
			sort_idx_q  <= '0;
			to_finish_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			attempt_q   <= attempt_n;
			sort_idx_q  <= sort_idx_n;
			to_finish_q <= to_finish_n;
		end
	end

	always_comb begin
		state_n      = state_q;
		attempt_n    = attempt_q;
		sort_idx_n   = sort_idx_q;
		to_finish_n  = to_finish_q;
		cmd          = '0;
		cmd.sort_idx = sort_idx_q;
		s_tready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (action_t'(s_tuser) == ACT_TICK) begin
						state_n = ST_CHECK;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_CHECK: begin
				attempt_n = TRY_SWEEP;
				if (status.none_left) begin
					cmd.clear_res = 1'b1;
					state_n       = ST_FINISH;
				end else begin
					state_n = ST_FIND;
				end
			end
			ST_FIND: begin
				cmd.find      = 1'b1;
				cmd.from_zero = (attempt_q != TRY_SWEEP);
				state_n       = ST_EVAL;
			end
			ST_EVAL: begin
				sort_idx_n  = '0;
				to_finish_n = 1'b0;
				priority if (status.found || attempt_q == TRY_SWITCHED) begin
					state_n = ST_RUN;
				end else if (attempt_q == TRY_SWEEP) begin
					cmd.reset_sp = 1'b1;
					attempt_n    = TRY_RESTART;
					if (status.quantum_hit) begin
						cmd.do_switch = 1'b1;
						state_n       = status.phase ? ST_FIND : ST_SORT;
					end else begin
						state_n = ST_FIND;
					end
				end else begin
					cmd.do_switch = 1'b1;
					attempt_n     = TRY_SWITCHED;
					state_n       = status.phase ? ST_FIND : ST_SORT;
				end
			end
			ST_RUN: begin
				cmd.run     = 1'b1;
				sort_idx_n  = '0;
				to_finish_n = 1'b1;
				state_n     = status.age_due ? ST_SORT : ST_FINISH;
			end
			ST_SORT: begin
				cmd.sort_step = 1'b1;
				sort_idx_n    = sort_idx_q + SLOT_W'(1);
				if (sort_idx_q == SLOT_W'(MAX_PROCS - 1)) begin
					state_n = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.sort_commit = 1'b1;
				state_n         = to_finish_q ? ST_FINISH : ST_FIND;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/rrpas_dp.sv]
`default_nettype none
module rrpas_dp (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire [rrpas_pkg::PCNT_W-1:0]           process_count,
	input  wire [rrpas_pkg::QUANT_W-1:0]          quantum_ticks,
	input  wire [rrpas_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  wire                                   m_tready,
	input  wire rrpas_pkg::dp_cmd_t               cmd,
	output rrpas_pkg::dp_status_t                 status,
	output logic                                  m_tvalid,
	output logic [rrpas_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                  m_tuser
);
	import rrpas_pkg::*;

	logic [ID_W-1:0]        id_q     [MAX_PROCS];
	logic [BURST_W-1:0]     burst_q  [MAX_PROCS];
	logic [PRIO_W-1:0]      prio_q   [MAX_PROCS];
	logic [SLOT_W-1:0]      pos_q    [MAX_PROCS];
	logic [SLOT_W-1:0]      newpos_q [MAX_PROCS];
	logic                   phase_q;
	logic [CNT_W-1:0]       sp_q;
	logic [TICK_W-1:0]      ticks_q;
	logic                   found_q;
	logic [SLOT_W-1:0]      fpos_q;
	logic [SLOT_W-1:0]      fslot_q;
	logic                   res_ran_q;
	logic [2:0]             res_slot_q;
	logic [ID_W-1:0]        res_id_q;
	logic [BURST_W-1:0]     res_burst_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   m_tuser_q;

	logic [2:0]         in_slot;
	logic [ID_W-1:0]    in_id;
	logic [BURST_W-1:0] in_burst;
	logic [PRIO_W-1:0]  in_prio;

	logic [CNT_W-1:0]   n_use;
	logic               any_left;
	logic [CNT_W-1:0]   start;
	logic [SLOT_W-1:0]  posk [MAX_PROCS];
	logic [SLOT_W-1:0]  slot_by_pos [MAX_PROCS];
	logic [MAX_PROCS-1:0] hit;
	logic               find_ok;
	logic [SLOT_W-1:0]  find_pos;
	logic [PRIO_W-1:0]  key_prio;
	logic [SLOT_W-1:0]  key_pos;
	logic               key_active;
	logic [CNT_W-1:0]   rank_cnt;
	logic [BURST_W-1:0] run_burst;
	logic [BURST_W-1:0] run_next;
	logic               age_due;

	assign in_slot  = s_tdata[2:0];
	assign in_id    = s_tdata[18:3];
	assign in_burst = s_tdata[34:19];
	assign in_prio  = s_tdata[41:35];

	always_comb begin
		n_use = (int'(process_count) > MAX_PROCS) ? CNT_W'(MAX_PROCS) : CNT_W'(process_count);
		any_left = 1'b0;
		for (int k = 0; k < MAX_PROCS; k++) begin
			if (CNT_W'(k) < n_use && burst_q[k] != '0) begin
				any_left = 1'b1;
			end
		end
	end

	// Runnable sweep positions at or after the start, then the first of them.
	always_comb begin
		start = cmd.from_zero ? '0 : sp_q;
		hit   = '0;
		for (int k = 0; k < MAX_PROCS; k++) begin
			posk[k] = phase_q ? pos_q[k] : SLOT_W'(k);
		end
		for (int p = 0; p < MAX_PROCS; p++) begin
			slot_by_pos[p] = '0;
			for (int k = 0; k < MAX_PROCS; k++) begin
				if (posk[k] == SLOT_W'(p)) begin
					slot_by_pos[p] = SLOT_W'(k);
					if (CNT_W'(k) < n_use && burst_q[k] != '0 &&
					    CNT_W'(p) < n_use && CNT_W'(p) >= start) begin
						hit[p] = 1'b1;
					end
				end
			end
		end
		find_ok  = 1'b0;
		find_pos = '0;
		for (int p = MAX_PROCS - 1; p >= 0; p--) begin
			if (hit[p]) begin
				find_ok  = 1'b1;
				find_pos = SLOT_W'(p);
			end
		end
	end

	// Stable rank of one slot among the slots held in the used part of the order.
	always_comb begin
		key_prio   = prio_q[cmd.sort_idx];
		key_pos    = pos_q[cmd.sort_idx];
		key_active = CNT_W'(key_pos) < n_use;
		rank_cnt   = '0;
		for (int m = 0; m < MAX_PROCS; m++) begin
			if (CNT_W'(pos_q[m]) < n_use &&
			    (prio_q[m] < key_prio || (prio_q[m] == key_prio && pos_q[m] < key_pos))) begin
				rank_cnt = rank_cnt + CNT_W'(1);
			end
		end
	end

	assign run_burst = burst_q[fslot_q];
	assign run_next  = (run_burst != '0) ? run_burst - BURST_W'(1) : run_burst;
	assign age_due   = phase_q && ((fpos_q % SLOT_W'(AGING_STRIDE)) == SLOT_W'(1));

	always_comb begin
		status.none_left   = !any_left;
		status.found       = found_q;
		status.quantum_hit = ticks_q >= TICK_W'(quantum_ticks);
		status.phase       = phase_q;
		status.age_due     = age_due;
		status.out_free    = !m_tvalid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 1'b0;
			sp_q       <= '0;
			ticks_q    <= '0;
			found_q    <= 1'b0;
			fpos_q     <= '0;
			fslot_q    <= '0;
			m_tvalid_q <= 1'b0;
			for (int k = 0; k < MAX_PROCS; k++) begin
				pos_q[k] <= SLOT_W'(k);
			end
		end else begin
			if (cmd.find) begin
				found_q <= find_ok;
				fpos_q  <= find_pos;
				fslot_q <= slot_by_pos[find_pos];
			end
			if (cmd.do_switch) begin
				phase_q <= !phase_q;
				ticks_q <= '0;
				if (!phase_q) begin
					for (int k = 0; k < MAX_PROCS; k++) begin
						pos_q[k] <= SLOT_W'(k);
					end
				end
			end
			if (cmd.reset_sp) begin
				sp_q <= '0;
			end
			if (cmd.run) begin
				sp_q <= CNT_W'(fpos_q) + CNT_W'(1);
				if (ticks_q != TICK_W'(TICKS_MAX)) begin
					ticks_q <= ticks_q + TICK_W'(1);
				end
			end
			if (cmd.sort_commit) begin
				for (int k = 0; k < MAX_PROCS; k++) begin
					pos_q[k] <= newpos_q[k];
				end
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q[SLOT_W'(in_slot)]    <= in_id;
			burst_q[SLOT_W'(in_slot)] <= in_burst;
			prio_q[SLOT_W'(in_slot)]  <= in_prio;
		end
		if (cmd.run) begin
			burst_q[fslot_q] <= run_next;
			res_ran_q        <= 1'b1;
			res_slot_q       <= 3'(fslot_q);
			res_id_q         <= id_q[fslot_q];
			res_burst_q      <= run_next;
			if (age_due) begin
				for (int i = 0; i < MAX_PROCS; i++) begin
					if (prio_q[i] != '0) begin
						prio_q[i] <= prio_q[i] - PRIO_W'(1);
					end
				end
			end
		end
		if (cmd.clear_res) begin
			res_ran_q   <= 1'b0;
			res_slot_q  <= '0;
			res_id_q    <= '0;
			res_burst_q <= '0;
		end
		if (cmd.sort_step) begin
			newpos_q[cmd.sort_idx] <= key_active ? SLOT_W'(rank_cnt) : key_pos;
		end
		if (cmd.emit) begin
			m_tdata_q <= OUT_TDATA_W'({!any_left, phase_q, res_burst_q, res_id_q, res_slot_q});
			m_tuser_q <= res_ran_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
`default_nettype wire

[hw/rtl/rrpas_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module rrpas_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        s_tuser,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire        m_tuser
);

	`ASSERT_PROP(a_out_hold, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
	`ASSERT_PROP(a_idle_tick, clk, arst_n, (m_tvalid && !m_tuser) |-> (m_tdata[36] && (m_tdata[34:0] == 35'd0)))
	`ASSERT_NEVER(a_done_burst, clk, arst_n, m_tvalid && m_tuser && m_tdata[36] && (m_tdata[34:19] != 16'd0))
	`ASSERT_PROP(a_tick_busy, clk, arst_n, (s_tvalid && s_tready && s_tuser) |=> !s_tready)

endmodule

bind round_robin_priority_aging_scheduler_unit rrpas_checker u_checker (.*);
`default_nettype wire
